// ===== rtl/core/wps_pkg.sv =====
// shared types, register codes and cordic constants of the pose smoother
`timescale 1ns / 1ps
package wps_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W = 4;
    localparam int ENT_W = 144;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_MAX_AGE = 2'd1,
        REG_DECAY = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] heading;
        logic [31:0] stamp;
    } hist_ent_t;

    typedef struct packed {
        logic start;
        logic vect;
    } cord_ctl_t;

    function automatic logic [31:0] phase_tab(input logic [ITER_W-1:0] i);
        logic [31:0] v;
        case (i)
            4'd0: v = 32'd536870912;
            4'd1: v = 32'd316933406;
            4'd2: v = 32'd167458907;
            4'd3: v = 32'd85004756;
            4'd4: v = 32'd42667331;
            4'd5: v = 32'd21354465;
            4'd6: v = 32'd10679838;
            4'd7: v = 32'd5340245;
            4'd8: v = 32'd2670163;
            4'd9: v = 32'd1335087;
            4'd10: v = 32'd667544;
            4'd11: v = 32'd333772;
            4'd12: v = 32'd166886;
            4'd13: v = 32'd83443;
            4'd14: v = 32'd41722;
            4'd15: v = 32'd20861;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/wps_ram.sv =====
// generic single-write ram with registered read
`timescale 1ns / 1ps
module wps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/wps_cordic.sv =====
// shared cordic unit, rotation for sine and cosine, vectoring for phase
`timescale 1ns / 1ps
module wps_cordic #(
    parameter int CW = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wps_pkg::cord_ctl_t     ctl,
    input  logic signed [CW-1:0]   x_in,
    input  logic signed [CW-1:0]   y_in,
    input  logic [31:0]            z_in,
    output logic                   done,
    output logic signed [CW-1:0]   x_out,
    output logic signed [CW-1:0]   y_out,
    output logic [31:0]            z_out
);
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next, dx, dy;
    logic [31:0] z_reg, z_next, tab;
    logic [wps_pkg::ITER_W-1:0] iter_reg;
    logic busy_reg, done_reg, vect_reg, dir;

    always_comb begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        tab = wps_pkg::phase_tab(iter_reg);
        dir = vect_reg ? !(y_reg > 0) : !z_reg[31];
        if (dir) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - tab;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + tab;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && iter_reg == wps_pkg::ITER_W'(wps_pkg::CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
            vect_reg <= ctl.vect;
            iter_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            iter_reg <= iter_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ===== rtl/core/wps_div.sv =====
// bit-serial rounded division of a signed sum by the total weight
`timescale 1ns / 1ps
module wps_div #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 22
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic [31:0]             quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] mag_reg, q_reg, abs_num;
    logic [DEN_W:0] rem_reg, rem_sh;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg, done_reg, neg_reg, ge;

    always_comb begin
        abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_sh = {rem_reg[DEN_W-1:0], mag_reg[NUM_W-1]};
        ge = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= abs_num + NUM_W'(den >> 1);
            rem_reg <= '0;
            q_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
            cnt_reg <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            mag_reg <= mag_reg << 1;
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            q_reg <= {q_reg[NUM_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (32'd0 - q_reg[31:0]) : q_reg[31:0];
endmodule

// ===== rtl/core/weighted_pose_smoother.sv =====
// top level: pose history, sequencer, shared multiplier, cordic and divider
//
// Usage: pose items enter on the s_ channel (valid/ready) and one smoothed
// pose leaves on the m_ channel (valid/ready) per item. Registers are written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// One item is handled at a time; s_ready is high only in the idle state.
// For each item the sequencer appends it, drops the oldest samples that lie
// outside the window or exceed the age limit, then for each kept sample reads
// the ram, runs the cordic and does six multiply/accumulate pairs on the single
// 18x33 multiplier, then runs three bit-serial divisions and the heading
// vectoring, which is skipped when both heading sums are zero. The next item
// is taken once the sequencer is back in idle; the shared cordic and the
// bit-serial divider take most of the time.
// The finished result sits in an output register; a new item is accepted
// while it waits, and the sequencer holds before its final write until the
// receiver has taken the previous result.
// Reset (synchronous, active low) empties the history and loads the
// register defaults: window 10, age 1000 ms, decay 58982.
`timescale 1ns / 1ps
module weighted_pose_smoother #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    input  logic signed [15:0]    s_heading,
    input  logic [31:0]           s_stamp_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_avg_x,
    output logic signed [31:0]    m_avg_y,
    output logic signed [31:0]    m_avg_z,
    output logic signed [15:0]    m_avg_heading,
    input  logic                  cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0] cfg_data
);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int WC_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int SUM_W = 49 + CNT_W;
    localparam int TW_W = 17 + CNT_W;
    localparam int SC_W = 35 + CNT_W;
    localparam int CW = SC_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_APPEND, S_DROP_RD, S_DROP_CHK, S_ACC_RD, S_SC_START, S_SC_RUN,
        S_MUL, S_ADD, S_DIV_START, S_DIV_RUN, S_VEC_START, S_VEC_RUN, S_OUT
    } state_t;

    state_t state_reg;
    logic [4:0] window_reg;
    logic [15:0] max_age_reg, decay_reg;
    logic [CNT_W-1:0] count_reg, left_reg;
    logic [IDX_W-1:0] oldest_reg, rd_ptr_reg;
    wps_pkg::hist_ent_t in_reg, ent;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SC_W-1:0] sc_reg, ss_reg;
    logic [TW_W-1:0] tw_reg;
    logic [16:0] w_reg;
    logic signed [17:0] c_reg, s_reg;
    logic signed [50:0] prod_reg;
    logic [2:0] op_reg;
    logic [1:0] div_sel_reg;
    logic flip_reg;
    logic [31:0] avx_reg, avy_reg, avz_reg;
    logic [15:0] avh_reg;
    logic m_valid_reg;

    logic [WC_W-1:0] win_eff;
    logic [4:0] win5;
    logic full;
    logic [IDX_W-1:0] oldest_a, slot, oldest_inc, rd_dec;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W:0] slot_sum;
    logic drop;
    logic signed [32:0] mul_op;
    logic signed [50:0] prod_next;
    logic signed [15:0] ang;
    logic signed [16:0] ang_f;
    logic sc_flip;
    logic signed [CW-1:0] cr_c, cr_s;
    logic [31:0] vz_round;

    wps_pkg::cord_ctl_t cord_ctl;
    logic signed [CW-1:0] cord_x_in, cord_y_in, cord_x, cord_y;
    logic [31:0] cord_z_in, cord_z;
    logic cord_done;

    logic ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [wps_pkg::ENT_W-1:0] ram_rdata;

    logic div_start, div_done;
    logic signed [SUM_W-1:0] div_num;
    logic [31:0] div_quot;

    assign ent = wps_pkg::hist_ent_t'(ram_rdata);

    always_comb begin
        win5 = (window_reg == 5'd0) ? 5'd1 : window_reg;
        win_eff = (WC_W'(win5) > WC_W'(MAX_DEPTH)) ? WC_W'(MAX_DEPTH) : WC_W'(win5);
        full = (count_reg == CNT_W'(MAX_DEPTH));
        oldest_inc = (oldest_reg == IDX_W'(MAX_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
        oldest_a = full ? oldest_inc : oldest_reg;
        count_a = full ? count_reg - 1'b1 : count_reg;
        slot_sum = (CNT_W + 1)'(oldest_a) + (CNT_W + 1)'(count_a);
        slot = (slot_sum >= (CNT_W + 1)'(MAX_DEPTH)) ?
               IDX_W'(slot_sum - (CNT_W + 1)'(MAX_DEPTH)) : IDX_W'(slot_sum);
        rd_dec = (rd_ptr_reg == '0) ? IDX_W'(MAX_DEPTH - 1) : rd_ptr_reg - 1'b1;
        drop = (count_reg > CNT_W'(1)) &&
               ((WC_W'(count_reg) > win_eff) ||
                ((in_reg.stamp - ent.stamp) > 32'(max_age_reg)));

        case (op_reg)
            3'd0: mul_op = 33'(ent.x);
            3'd1: mul_op = 33'(ent.y);
            3'd2: mul_op = 33'(ent.z);
            3'd3: mul_op = 33'(c_reg);
            3'd4: mul_op = 33'(s_reg);
            default: mul_op = $signed({17'd0, decay_reg});
        endcase
        prod_next = $signed({1'b0, w_reg}) * mul_op;

        ang = ent.heading;
        sc_flip = (ang > 16'sd16384) || (ang < -16'sd16384);
        if (ang > 16'sd16384) begin
            ang_f = 17'(ang) - 17'sd32768;
        end else if (ang < -16'sd16384) begin
            ang_f = 17'(ang) + 17'sd32768;
        end else begin
            ang_f = 17'(ang);
        end

        cr_c = (cord_x + $signed(CW'(16384))) >>> 15;
        cr_s = (cord_y + $signed(CW'(16384))) >>> 15;
        vz_round = cord_z + 32'h0000_8000;

        cord_ctl.start = (state_reg == S_SC_START) ||
                         ((state_reg == S_VEC_START) && !(sc_reg == '0 && ss_reg == '0));
        cord_ctl.vect = (state_reg == S_VEC_START);
        if (state_reg == S_VEC_START) begin
            cord_x_in = sc_reg[SC_W-1] ? -CW'(sc_reg) : CW'(sc_reg);
            cord_y_in = sc_reg[SC_W-1] ? -CW'(ss_reg) : CW'(ss_reg);
            cord_z_in = sc_reg[SC_W-1] ? 32'h8000_0000 : 32'd0;
        end else begin
            cord_x_in = CW'(wps_pkg::CORDIC_START);
            cord_y_in = '0;
            cord_z_in = {ang_f[15:0], 16'd0};
        end

        case (div_sel_reg)
            2'd0: div_num = sx_reg;
            2'd1: div_num = sy_reg;
            default: div_num = sz_reg;
        endcase
        div_start = (state_reg == S_DIV_START);

        ram_we = (state_reg == S_APPEND);
        ram_re = (state_reg == S_DROP_RD) || (state_reg == S_ACC_RD);
        ram_raddr = (state_reg == S_DROP_RD) ? oldest_reg : rd_ptr_reg;
    end

    wps_ram #(
        .WIDTH(wps_pkg::ENT_W),
        .DEPTH(MAX_DEPTH)
    ) u_hist (
        .aclk(aclk),
        .we(ram_we),
        .waddr(slot),
        .wdata(in_reg),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    wps_cordic #(
        .CW(CW)
    ) u_cordic (
        .aclk(aclk),
        .aresetn(aresetn),
        .ctl(cord_ctl),
        .x_in(cord_x_in),
        .y_in(cord_y_in),
        .z_in(cord_z_in),
        .done(cord_done),
        .x_out(cord_x),
        .y_out(cord_y),
        .z_out(cord_z)
    );

    wps_div #(
        .NUM_W(SUM_W),
        .DEN_W(TW_W)
    ) u_div (
        .aclk(aclk),
        .aresetn(aresetn),
        .start(div_start),
        .num(div_num),
        .den(tw_reg),
        .done(div_done),
        .quot(div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            window_reg <= 5'd10;
            max_age_reg <= 16'd1000;
            decay_reg <= 16'd58982;
            count_reg <= '0;
            oldest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    wps_pkg::REG_WINDOW: window_reg <= cfg_data[4:0];
                    wps_pkg::REG_MAX_AGE: max_age_reg <= cfg_data;
                    wps_pkg::REG_DECAY: decay_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg <= '{x: s_pos_x, y: s_pos_y, z: s_pos_z,
                                    heading: s_heading, stamp: s_stamp_ms};
                        state_reg <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    oldest_reg <= oldest_a;
                    count_reg <= count_a + 1'b1;
                    rd_ptr_reg <= slot;
                    state_reg <= S_DROP_RD;
                end
                S_DROP_RD: begin
                    state_reg <= S_DROP_CHK;
                end
                S_DROP_CHK: begin
                    if (drop) begin
                        oldest_reg <= oldest_inc;
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DROP_RD;
                    end else begin
                        left_reg <= count_reg;
                        w_reg <= 17'd65536;
                        sx_reg <= '0;
                        sy_reg <= '0;
                        sz_reg <= '0;
                        sc_reg <= '0;
                        ss_reg <= '0;
                        tw_reg <= '0;
                        state_reg <= S_ACC_RD;
                    end
                end
                S_ACC_RD: begin
                    state_reg <= S_SC_START;
                end
                S_SC_START: begin
                    flip_reg <= sc_flip;
                    state_reg <= S_SC_RUN;
                end
                S_SC_RUN: begin
                    if (cord_done) begin
                        c_reg <= 18'(flip_reg ? -cr_c : cr_c);
                        s_reg <= 18'(flip_reg ? -cr_s : cr_s);
                        op_reg <= 3'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg <= prod_next;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    op_reg <= op_reg + 1'b1;
                    state_reg <= S_MUL;
                    case (op_reg)
                        3'd0: sx_reg <= sx_reg + SUM_W'(prod_reg);
                        3'd1: sy_reg <= sy_reg + SUM_W'(prod_reg);
                        3'd2: sz_reg <= sz_reg + SUM_W'(prod_reg);
                        3'd3: sc_reg <= sc_reg + SC_W'(prod_reg);
                        3'd4: ss_reg <= ss_reg + SC_W'(prod_reg);
                        default: begin
                            w_reg <= prod_reg[32:16];
                            tw_reg <= tw_reg + TW_W'(w_reg);
                            left_reg <= left_reg - 1'b1;
                            rd_ptr_reg <= rd_dec;
                            div_sel_reg <= 2'd0;
                            state_reg <= (left_reg == CNT_W'(1)) ? S_DIV_START : S_ACC_RD;
                        end
                    endcase
                end
                S_DIV_START: begin
                    state_reg <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    if (div_done) begin
                        div_sel_reg <= div_sel_reg + 1'b1;
                        case (div_sel_reg)
                            2'd0: avx_reg <= div_quot;
                            2'd1: avy_reg <= div_quot;
                            default: avz_reg <= div_quot;
                        endcase
                        state_reg <= (div_sel_reg == 2'd2) ? S_VEC_START : S_DIV_START;
                    end
                end
                S_VEC_START: begin
                    if (sc_reg == '0 && ss_reg == '0) begin
                        avh_reg <= 16'd0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_VEC_RUN;
                    end
                end
                S_VEC_RUN: begin
                    if (cord_done) begin
                        avh_reg <= vz_round[31:16];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_avg_x <= avx_reg;
                        m_avg_y <= avy_reg;
                        m_avg_z <= avz_reg;
                        m_avg_heading <= avh_reg;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while a previous item is still in work");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DEPTH))
        else $error("history count beyond depth");

    a_newest_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##2 count_reg != '0)
        else $error("history empty after an item was appended");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT && m_valid_reg && !m_ready |=> m_valid_reg && state_reg == S_OUT)
        else $error("waiting result overwritten");
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the weighted pose smoother: directed and random items
`timescale 1ns / 1ps
module tb_top;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [15:0] heading;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_pos_x = '0;
    logic signed [31:0] s_pos_y = '0;
    logic signed [31:0] s_pos_z = '0;
    logic signed [15:0] s_heading = '0;
    logic [31:0] s_stamp_ms = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_avg_x;
    logic signed [31:0] m_avg_y;
    logic signed [31:0] m_avg_z;
    logic signed [15:0] m_avg_heading;
    logic cfg_we = 1'b0;
    logic [wps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [wps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    weighted_pose_smoother dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_heading(s_heading), .s_stamp_ms(s_stamp_ms),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_avg_x(m_avg_x), .m_avg_y(m_avg_y), .m_avg_z(m_avg_z),
        .m_avg_heading(m_avg_heading),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state
    logic signed [31:0] hist_x[DEPTH];
    logic signed [31:0] hist_y[DEPTH];
    logic signed [31:0] hist_z[DEPTH];
    logic signed [15:0] hist_hd[DEPTH];
    logic [31:0] hist_stamp[DEPTH];
    int unsigned hist_count = 0;
    int unsigned hist_oldest = 0;
    int unsigned window_reg = 10;
    logic [31:0] max_age_reg = 32'd1000;
    longint decay_reg = 58982;

    pose_t pending_poses[$];
    int unsigned mismatches = 0;
    int unsigned stall_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic [31:0] stamp_now = 32'd0;

    const longint angle_step[wps_pkg::CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    function automatic void rotate_heading(input longint ang, output longint c,
                                           output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        flip = 1'b0;
        if (ang > 16384) begin
            ang -= 32768;
            flip = 1'b1;
        end else if (ang < -16384) begin
            ang += 32768;
            flip = 1'b1;
        end
        x = wps_pkg::CORDIC_START;
        y = 0;
        z = ang * 65536;
        for (int i = 0; i < wps_pkg::CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= angle_step[i];
            end else begin
                x += dx; y -= dy; z += angle_step[i];
            end
        end
        x = (x + 16384) >>> 15;
        y = (y + 16384) >>> 15;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] mean_phase(input longint cx, input longint sy);
        logic [31:0] z;
        longint dx, dy;
        z = 32'd0;
        if (cx == 0 && sy == 0) return 32'd0;
        if (cx < 0) begin
            cx = -cx; sy = -sy; z = 32'h8000_0000;
        end
        for (int i = 0; i < wps_pkg::CORDIC_STEPS; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (sy > 0) begin
                cx += dx; sy -= dy; z += 32'(angle_step[i]);
            end else begin
                cx -= dx; sy += dy; z -= 32'(angle_step[i]);
            end
        end
        return z;
    endfunction

    function automatic longint nearest_div(input longint num, input longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic void drop_oldest_pose();
        hist_oldest = (hist_oldest + 1) % DEPTH;
        hist_count--;
    endfunction

    function automatic pose_t smooth_pose(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz,
                                          input logic signed [15:0] hd,
                                          input logic [31:0] stamp);
        int unsigned win, slot, idx;
        longint w, sx, sy, sz, ss, sc, tw, c, s;
        logic [31:0] age, ph;
        pose_t r;
        win = window_reg;
        if (win == 0) win = 1;
        if (win > DEPTH) win = DEPTH;
        if (hist_count >= DEPTH) drop_oldest_pose();
        slot = (hist_oldest + hist_count) % DEPTH;
        hist_x[slot] = px;
        hist_y[slot] = py;
        hist_z[slot] = pz;
        hist_hd[slot] = hd;
        hist_stamp[slot] = stamp;
        hist_count++;
        forever begin
            if (hist_count <= 1) break;
            age = stamp - hist_stamp[hist_oldest];
            if (hist_count > win || age > max_age_reg) drop_oldest_pose();
            else break;
        end
        w = 65536;
        sx = 0; sy = 0; sz = 0; ss = 0; sc = 0; tw = 0;
        for (int unsigned k = 0; k < hist_count; k++) begin
            idx = (hist_oldest + hist_count - 1 - k) % DEPTH;
            sx += w * longint'(hist_x[idx]);
            sy += w * longint'(hist_y[idx]);
            sz += w * longint'(hist_z[idx]);
            rotate_heading(longint'(hist_hd[idx]), c, s);
            sc += w * c;
            ss += w * s;
            tw += w;
            w = (w * decay_reg) >> 16;
        end
        r.x = 32'(nearest_div(sx, tw));
        r.y = 32'(nearest_div(sy, tw));
        r.z = 32'(nearest_div(sz, tw));
        ph = mean_phase(sc, ss) + 32'h8000;
        r.heading = ph[31:16];
        return r;
    endfunction

    // result side: stall pattern, comparison and watchdog
    always @(posedge aclk) begin
        pose_t e;
        if (m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: x=%h y=%h z=%h hd=%h",
                             m_avg_x, m_avg_y, m_avg_z, m_avg_heading);
            end else begin
                e = pending_poses[0];
                pending_poses.delete(0);
                if (e.x !== m_avg_x || e.y !== m_avg_y || e.z !== m_avg_z ||
                        e.heading !== m_avg_heading) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h hd=%h got x=%h y=%h z=%h hd=%h",
                                 e.x, e.y, e.z, e.heading,
                                 m_avg_x, m_avg_y, m_avg_z, m_avg_heading);
                end
            end
        end
        if ((m_valid && m_ready) || (s_valid && s_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("weighted_pose_smoother test failed");
            $finish;
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pose(input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] pz, input logic signed [15:0] hd,
                             input logic [31:0] stamp);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_heading <= hd;
        s_stamp_ms <= stamp;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_poses.insert(pending_poses.size(), smooth_pose(px, py, pz, hd, stamp));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input wps_pkg::cfg_reg_t idx,
                             input logic [wps_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            wps_pkg::REG_WINDOW: window_reg = val[4:0];
            wps_pkg::REG_MAX_AGE: max_age_reg = val;
            wps_pkg::REG_DECAY: decay_reg = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned win, input int unsigned age,
                            input int unsigned dec);
        drain();
        write_reg(wps_pkg::REG_WINDOW, 16'(win));
        write_reg(wps_pkg::REG_MAX_AGE, 16'(age));
        write_reg(wps_pkg::REG_DECAY, 16'(dec));
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(131072)) - 65536);
            3, 4: return $urandom;
            default: return stamp_now * 32'd7 + $urandom_range(65535) - 32768;
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(16384 + int'($urandom_range(2)) - 1);
            3: return 16'(-16384 + int'($urandom_range(2)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(19))
            0: stamp_now = $urandom;
            1: stamp_now = stamp_now - $urandom_range(200);
            default: stamp_now = stamp_now + $urandom_range(300);
        endcase
        return stamp_now;
    endfunction

    task automatic test_field_extremes();
        send_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 16'sh7fff, 32'd0);
        send_pose(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, -16'sh8000, 32'd10);
        send_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd16384, 32'd20);
        send_pose(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sd16385, 32'd30);
        send_pose(32'sd65536, -32'sd65536, 32'sd1, -16'sd16385, 32'd40);
        send_pose(32'sd0, 32'sd0, 32'sd0, -16'sd16384, 32'hffff_ffff);
        send_pose(32'sd5, 32'sd6, 32'sd7, 16'sd0, 32'd5);
    endtask

    task automatic test_register_extremes();
        set_regs(0, 65535, 65535);
        send_pose(32'sd100, 32'sd200, 32'sd300, 16'sd1000, 32'd100);
        send_pose(32'sd400, 32'sd500, 32'sd600, 16'sd2000, 32'd101);
        // window above depth, so the full history wraps
        set_regs(31, 65535, 65535);
        for (int i = 0; i < 18; i++)
            send_pose(pick_coord(), pick_coord(), pick_coord(), pick_heading(), 32'(200 + i));
        set_regs(16, 0, 0);
        send_pose(32'sd1, 32'sd2, 32'sd3, 16'sd100, 32'd300);
        send_pose(32'sd4, 32'sd5, 32'sd6, -16'sd100, 32'd300);
        // stamps going backwards
        send_pose(32'sd7, 32'sd8, 32'sd9, 16'sd0, 32'd299);
        // opposite headings at nearly equal weight
        set_regs(2, 65535, 65535);
        send_pose(32'sd0, 32'sd0, 32'sd0, 16'sd0, 32'd400);
        send_pose(32'sd0, 32'sd0, 32'sd0, -16'sh8000, 32'd400);
    endtask

    task automatic test_random_phase(input int unsigned n_items, input int unsigned sidle,
                                     input int unsigned ridle);
        int unsigned win, age, dec;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                win = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 8);
                age = ($urandom_range(3) == 0) ? $urandom_range(65535) :
                                                 $urandom_range(300, 1500);
                dec = ($urandom_range(4) == 0) ? $urandom_range(65535) :
                                                 $urandom_range(40000, 65535);
                set_regs(win, age, dec);
            end
            send_pose(pick_coord(), pick_coord(), pick_coord(), pick_heading(), next_stamp());
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 26;
        recv_idle_pct = 47;
        test_field_extremes();
        test_register_extremes();
        test_random_phase(430, 26, 47);
        test_random_phase(430, 47, 26);
        test_random_phase(440, 0, 0);
        drain();
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("weighted_pose_smoother test passed");
        else
            $display("weighted_pose_smoother test failed");
        $finish;
    end
endmodule

// ===== weighted_pose_smoother.f =====
rtl/core/wps_pkg.sv
rtl/core/wps_ram.sv
rtl/core/wps_cordic.sv
rtl/core/wps_div.sv
rtl/core/weighted_pose_smoother.sv
tb/tb_top.sv
